// File: rtl/core/cua_pkg.sv
// ----------------------------------------------------------------------------
// cua_pkg
// Shared types, codes and constants of the cascade UID assembler.
// ----------------------------------------------------------------------------
package cua_pkg;

  localparam logic [7:0] CASCADE_TAG = 8'h88;
  localparam logic [7:0] SAK_MORE    = 8'h04;
  localparam logic [7:0] SAK_MASK    = 8'h7F;

  localparam logic [7:0] SAK_INCOMPLETE = 8'h04;
  localparam logic [7:0] SAK_MINI       = 8'h09;
  localparam logic [7:0] SAK_CLASSIC1K  = 8'h08;
  localparam logic [7:0] SAK_CLASSIC4K  = 8'h18;
  localparam logic [7:0] SAK_ULTRALIGHT = 8'h00;
  localparam logic [7:0] SAK_PLUS_A     = 8'h10;
  localparam logic [7:0] SAK_PLUS_B     = 8'h11;
  localparam logic [7:0] SAK_ISO14443_4 = 8'h20;
  localparam logic [7:0] SAK_ISO18092   = 8'h40;

  localparam logic [1:0] LEVEL_NONE  = 2'd0;
  localparam logic [1:0] LEVEL_ONE   = 2'd1;
  localparam logic [1:0] LEVEL_TWO   = 2'd2;
  localparam logic [1:0] LEVEL_THREE = 2'd3;

  localparam logic [3:0] SIZE_NONE   = 4'd0;
  localparam logic [3:0] SIZE_SINGLE = 4'd4;
  localparam logic [3:0] SIZE_DOUBLE = 4'd7;
  localparam logic [3:0] SIZE_TRIPLE = 4'd10;

  localparam int UID_BYTES = 10;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NEXT    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_RF      = 3'd3,
    ST_BAD_UID = 3'd4,
    ST_BCC     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    XR_OK      = 2'd0,
    XR_TIMEOUT = 2'd1,
    XR_RF      = 2'd2,
    XR_OTHER   = 2'd3
  } xfer_result_t;

  typedef enum logic [3:0] {
    KIND_UNKNOWN    = 4'd0,
    KIND_INCOMPLETE = 4'd1,
    KIND_MINI       = 4'd2,
    KIND_CLASSIC1K  = 4'd3,
    KIND_CLASSIC4K  = 4'd4,
    KIND_ULTRALIGHT = 4'd5,
    KIND_PLUS       = 4'd6,
    KIND_ISO14443_4 = 4'd7,
    KIND_ISO18092   = 4'd8
  } kind_t;

  typedef logic [UID_BYTES-1:0][7:0] uid_t;

  typedef struct packed {
    logic         new_card;
    logic [15:0]  atqa;
    logic [3:0][7:0] frame;
    logic [7:0]   bcc;
    logic [7:0]   sak;
    xfer_result_t anticoll;
    xfer_result_t sel;
  } item_t;

  typedef struct packed {
    logic [1:0]  level;
    uid_t        uid;
    logic [15:0] atqa;
    logic [7:0]  sak;
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  next_level;
    logic [3:0]  size;
    uid_t        uid;
    logic [7:0]  sak;
    logic [15:0] atqa;
    kind_t       kind;
  } result_t;

  function automatic kind_t kind_of(input logic [7:0] sak);
    kind_t k;
    case (sak & SAK_MASK)
      SAK_INCOMPLETE:         k = KIND_INCOMPLETE;
      SAK_MINI:               k = KIND_MINI;
      SAK_CLASSIC1K:          k = KIND_CLASSIC1K;
      SAK_CLASSIC4K:          k = KIND_CLASSIC4K;
      SAK_ULTRALIGHT:         k = KIND_ULTRALIGHT;
      SAK_PLUS_A, SAK_PLUS_B: k = KIND_PLUS;
      SAK_ISO14443_4:         k = KIND_ISO14443_4;
      SAK_ISO18092:           k = KIND_ISO18092;
      default:                k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic status_t fail_status(input xfer_result_t code);
    status_t s;
    case (code)
      XR_TIMEOUT: s = ST_TIMEOUT;
      XR_RF:      s = ST_RF;
      default:    s = ST_BAD_UID;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/cascade_uid_assembler.sv
// ----------------------------------------------------------------------------
// cascade_uid_assembler
// Assembles a 4, 7 or 10 byte card UID from up to three cascade level words.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one cascade level per word:
//   the four anticollision bytes, BCC, SAK, the ATQA bytes and the outcome
//   codes of the anticollision and select exchanges. new_card restarts at
//   level one. Output channel (out_valid/out_ready) returns one result word
//   per input word: status, next level, UID size, UID store, SAK, ATQA and
//   card kind.
//   Path: an accepted word goes to the input register, then its result to the
//   result register, from which out_ready takes it.
//   Throughput: one word per cycle while the result side does not stall; the
//   card state is updated at the same edge that loads the result register.
//   Reset: level one, UID store, ATQA and SAK cleared, both registers empty.
//   Stall: a held result keeps its word; the input register still takes one
//   more word, then in_ready drops until out_ready frees the result register.
// ----------------------------------------------------------------------------
module cascade_uid_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        new_card,
  input  logic [7:0]  answer_to_request_lo,
  input  logic [7:0]  answer_to_request_hi,
  input  logic [7:0]  frame_byte_0,
  input  logic [7:0]  frame_byte_1,
  input  logic [7:0]  frame_byte_2,
  input  logic [7:0]  frame_byte_3,
  input  logic [7:0]  check_byte,
  input  logic [7:0]  select_answer,
  input  logic [1:0]  anticoll_result,
  input  logic [1:0]  select_result,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  next_level,
  output logic [3:0]  uid_length,
  output logic [63:0] uid_low_bytes,
  output logic [15:0] uid_high_bytes,
  output logic [7:0]  final_select_answer,
  output logic [15:0] answer_to_request,
  output logic [3:0]  card_kind
);

  cua_pkg::item_t   item_in;
  cua_pkg::item_t   item_q;
  logic             item_valid;
  cua_pkg::state_t  card;
  cua_pkg::state_t  card_next;
  cua_pkg::result_t res_next;
  cua_pkg::result_t res_q;
  logic             res_valid;
  logic             advance;

  assign item_in.new_card = new_card;
  assign item_in.atqa     = {answer_to_request_hi, answer_to_request_lo};
  assign item_in.frame    = {frame_byte_3, frame_byte_2, frame_byte_1, frame_byte_0};
  assign item_in.bcc      = check_byte;
  assign item_in.sak      = select_answer;
  assign item_in.anticoll = cua_pkg::xfer_result_t'(anticoll_result);
  assign item_in.sel      = cua_pkg::xfer_result_t'(select_result);

  assign advance  = item_valid && (!res_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

  cua_step u_step (
    .item (item_q),
    .cur  (card),
    .nxt  (card_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      card.level <= cua_pkg::LEVEL_ONE;
      card.uid   <= '0;
      card.atqa  <= 16'h0000;
      card.sak   <= 8'h00;
    end else if (advance) begin
      card <= card_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || out_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign out_valid           = res_valid;
  assign status              = res_q.status;
  assign next_level          = res_q.next_level;
  assign uid_length          = res_q.size;
  assign uid_low_bytes       = res_q.uid[7:0];
  assign uid_high_bytes      = res_q.uid[9:8];
  assign final_select_answer = res_q.sak;
  assign answer_to_request   = res_q.atqa;
  assign card_kind           = res_q.kind;

  a_size_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cua_pkg::ST_DONE) |->
      (uid_length == cua_pkg::SIZE_SINGLE) || (uid_length == cua_pkg::SIZE_DOUBLE) ||
      (uid_length == cua_pkg::SIZE_TRIPLE))
    else $error("complete result without a valid UID size");

  a_size_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cua_pkg::ST_DONE) |-> uid_length == cua_pkg::SIZE_NONE)
    else $error("incomplete result with nonzero UID size");

  a_level_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cua_pkg::ST_NEXT) |-> next_level == cua_pkg::LEVEL_ONE)
    else $error("level not returned to one");

  a_level_valid: assert property (@(posedge clk) disable iff (rst)
    card.level != cua_pkg::LEVEL_NONE)
    else $error("cascade level zero");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// File: rtl/core/cua_step.sv
// ----------------------------------------------------------------------------
// cua_step
// Combinational handling of one cascade level word: BCC and result checks,
// cascade decision, UID store update and result formation.
// ----------------------------------------------------------------------------
module cua_step (
  input  cua_pkg::item_t   item,
  input  cua_pkg::state_t  cur,
  output cua_pkg::state_t  nxt,
  output cua_pkg::result_t res
);

  logic              start;
  logic [1:0]        lvl;
  logic              more;
  logic              tag;
  logic              bcc_ok;
  cua_pkg::status_t  st;
  logic [3:0]        size;
  cua_pkg::state_t   s;

  assign start  = item.new_card || (cur.level == cua_pkg::LEVEL_ONE) ||
                  (cur.level == cua_pkg::LEVEL_NONE);
  assign lvl    = start ? cua_pkg::LEVEL_ONE : cur.level;
  assign more   = (item.sak & cua_pkg::SAK_MORE) != 8'h00;
  assign tag    = item.frame[0] == cua_pkg::CASCADE_TAG;
  assign bcc_ok = (item.frame[0] ^ item.frame[1] ^ item.frame[2] ^ item.frame[3])
                  == item.bcc;

  always_comb begin
    s       = cur;
    st      = cua_pkg::ST_DONE;
    size    = cua_pkg::SIZE_NONE;
    if (start) begin
      s.uid  = '0;
      s.sak  = 8'h00;
      s.atqa = item.atqa;
    end
    if (item.anticoll != cua_pkg::XR_OK) begin
      st = cua_pkg::fail_status(item.anticoll);
    end else if (!bcc_ok) begin
      st = cua_pkg::ST_BCC;
    end else if (item.sel != cua_pkg::XR_OK) begin
      st = cua_pkg::fail_status(item.sel);
    end else begin
      s.sak = item.sak;
      case (lvl)
        cua_pkg::LEVEL_ONE: begin
          if (tag || more) begin
            if (!tag) begin
              st = cua_pkg::ST_BAD_UID;
            end else begin
              s.uid[0] = item.frame[1];
              s.uid[1] = item.frame[2];
              s.uid[2] = item.frame[3];
              st       = cua_pkg::ST_NEXT;
            end
          end else begin
            s.uid[3:0] = item.frame;
            size       = cua_pkg::SIZE_SINGLE;
          end
        end
        cua_pkg::LEVEL_TWO: begin
          if (more) begin
            if (!tag) begin
              st = cua_pkg::ST_BAD_UID;
            end else begin
              s.uid[3] = item.frame[1];
              s.uid[4] = item.frame[2];
              s.uid[5] = item.frame[3];
              st       = cua_pkg::ST_NEXT;
            end
          end else begin
            s.uid[6:3] = item.frame;
            size       = cua_pkg::SIZE_DOUBLE;
          end
        end
        default: begin
          if (more) begin
            st = cua_pkg::ST_BAD_UID;
          end else begin
            s.uid[9:6] = item.frame;
            size       = cua_pkg::SIZE_TRIPLE;
          end
        end
      endcase
    end
    s.level = (st == cua_pkg::ST_NEXT) ? lvl + 2'd1 : cua_pkg::LEVEL_ONE;
  end

  assign nxt            = s;
  assign res.status     = st;
  assign res.next_level = s.level;
  assign res.size       = size;
  assign res.uid        = s.uid;
  assign res.sak        = s.sak;
  assign res.atqa       = s.atqa;
  assign res.kind       = cua_pkg::kind_of(s.sak);

endmodule

// File: verif/tb_cascade_uid_assembler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascade_uid_assembler
// Self-checking bench for the cascade UID assembler. A directed set of level
// words covers single, double and triple size cards, the cascade tag and SAK
// rules, every exchange failure and the check priority. Random card sequences
// follow, mixed with broken and noise words. A tracker class predicts every
// result word from the accepted input words and compares each received word
// field by field. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_cascade_uid_assembler;
  import cua_pkg::*;

  localparam int RANDOM_WORDS = 650;

  class card_uid_tracker;
    logic [1:0]  level_q;
    uid_t        uid_q;
    logic [15:0] atqa_q;
    logic [7:0]  sak_q;
    result_t     expected_cards[$];
    int          failures;

    function new();
      level_q  = LEVEL_ONE;
      uid_q    = '0;
      atqa_q   = '0;
      sak_q    = '0;
      failures = 0;
    endfunction

    function status_t exchange_status(input xfer_result_t code);
      if (code == XR_TIMEOUT) return ST_TIMEOUT;
      if (code == XR_RF) return ST_RF;
      return ST_BAD_UID;
    endfunction

    function kind_t card_class(input logic [7:0] sak);
      logic [7:0] masked;
      masked = sak & SAK_MASK;
      if (masked == SAK_INCOMPLETE) return KIND_INCOMPLETE;
      if (masked == SAK_MINI) return KIND_MINI;
      if (masked == SAK_CLASSIC1K) return KIND_CLASSIC1K;
      if (masked == SAK_CLASSIC4K) return KIND_CLASSIC4K;
      if (masked == SAK_ULTRALIGHT) return KIND_ULTRALIGHT;
      if (masked == SAK_PLUS_A || masked == SAK_PLUS_B) return KIND_PLUS;
      if (masked == SAK_ISO14443_4) return KIND_ISO14443_4;
      if (masked == SAK_ISO18092) return KIND_ISO18092;
      return KIND_UNKNOWN;
    endfunction

    function void take_level_word(input item_t w);
      result_t    r;
      logic [1:0] lvl;
      logic       more;
      logic       has_tag;
      status_t    st;
      logic [3:0] len;
      if (w.new_card || level_q == LEVEL_NONE) level_q = LEVEL_ONE;
      lvl = level_q;
      if (lvl == LEVEL_ONE) begin
        uid_q  = '0;
        sak_q  = '0;
        atqa_q = w.atqa;
      end
      st      = ST_DONE;
      len     = SIZE_NONE;
      more    = |(w.sak & SAK_MORE);
      has_tag = (w.frame[0] == CASCADE_TAG);
      if (w.anticoll != XR_OK) begin
        st = exchange_status(w.anticoll);
      end else if ((w.frame[0] ^ w.frame[1] ^ w.frame[2] ^ w.frame[3]) != w.bcc) begin
        st = ST_BCC;
      end else if (w.sel != XR_OK) begin
        st = exchange_status(w.sel);
      end else begin
        sak_q = w.sak;
        if (lvl == LEVEL_ONE) begin
          if (has_tag || more) begin
            if (!has_tag) begin
              st = ST_BAD_UID;
            end else begin
              for (int i = 0; i < 3; i++) uid_q[i] = w.frame[i+1];
              st = ST_NEXT;
            end
          end else begin
            for (int i = 0; i < 4; i++) uid_q[i] = w.frame[i];
            len = SIZE_SINGLE;
          end
        end else if (lvl == LEVEL_TWO) begin
          if (more) begin
            if (!has_tag) begin
              st = ST_BAD_UID;
            end else begin
              for (int i = 0; i < 3; i++) uid_q[3+i] = w.frame[i+1];
              st = ST_NEXT;
            end
          end else begin
            for (int i = 0; i < 4; i++) uid_q[3+i] = w.frame[i];
            len = SIZE_DOUBLE;
          end
        end else begin
          if (more) begin
            st = ST_BAD_UID;
          end else begin
            for (int i = 0; i < 4; i++) uid_q[6+i] = w.frame[i];
            len = SIZE_TRIPLE;
          end
        end
      end
      level_q      = (st == ST_NEXT) ? lvl + 2'd1 : LEVEL_ONE;
      r.status     = st;
      r.next_level = level_q;
      r.size       = len;
      r.uid        = uid_q;
      r.sak        = sak_q;
      r.atqa       = atqa_q;
      r.kind       = card_class(sak_q);
      expected_cards.push_back(r);
    endfunction

    function string show(input result_t r);
      return $sformatf("st=%0d lvl=%0d len=%0d uid=%h sak=%h atqa=%h kind=%0d",
                       r.status, r.next_level, r.size, r.uid, r.sak, r.atqa, r.kind);
    endfunction

    function void check_card_result(input result_t got);
      result_t exp;
      if (expected_cards.size() == 0) begin
        if (failures < 10) $display("unexpected result word: %s", show(got));
        failures++;
        return;
      end
      exp = expected_cards.pop_front();
      if (got.status !== exp.status || got.next_level !== exp.next_level ||
          got.size !== exp.size || got.uid !== exp.uid || got.sak !== exp.sak ||
          got.atqa !== exp.atqa || got.kind !== exp.kind) begin
        if (failures < 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  exp %s", show(exp));
          $display("  got %s", show(got));
        end
        failures++;
      end
    endfunction
  endclass

  typedef enum {RX_FREE, RX_ALTERNATE, RX_COIN, RX_CHOKED} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        new_card = 1'b0;
  logic [7:0]  answer_to_request_lo = '0;
  logic [7:0]  answer_to_request_hi = '0;
  logic [7:0]  frame_byte_0 = '0;
  logic [7:0]  frame_byte_1 = '0;
  logic [7:0]  frame_byte_2 = '0;
  logic [7:0]  frame_byte_3 = '0;
  logic [7:0]  check_byte = '0;
  logic [7:0]  select_answer = '0;
  logic [1:0]  anticoll_result = '0;
  logic [1:0]  select_result = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [1:0]  next_level;
  logic [3:0]  uid_length;
  logic [63:0] uid_low_bytes;
  logic [15:0] uid_high_bytes;
  logic [7:0]  final_select_answer;
  logic [15:0] answer_to_request;
  logic [3:0]  card_kind;

  card_uid_tracker uid_track = new();
  item_t           level_words[$];
  result_t         seen;
  rx_mode_e        rx_mode = RX_FREE;
  int unsigned     rx_window = 0;
  logic            rx_toggle = 1'b0;

  cascade_uid_assembler u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .new_card            (new_card),
    .answer_to_request_lo(answer_to_request_lo),
    .answer_to_request_hi(answer_to_request_hi),
    .frame_byte_0        (frame_byte_0),
    .frame_byte_1        (frame_byte_1),
    .frame_byte_2        (frame_byte_2),
    .frame_byte_3        (frame_byte_3),
    .check_byte          (check_byte),
    .select_answer       (select_answer),
    .anticoll_result     (anticoll_result),
    .select_result       (select_result),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .next_level          (next_level),
    .uid_length          (uid_length),
    .uid_low_bytes       (uid_low_bytes),
    .uid_high_bytes      (uid_high_bytes),
    .final_select_answer (final_select_answer),
    .answer_to_request   (answer_to_request),
    .card_kind           (card_kind)
  );

  always #1 clk = ~clk;

  function automatic item_t sealed(input item_t w);
    w.bcc = w.frame[0] ^ w.frame[1] ^ w.frame[2] ^ w.frame[3];
    return w;
  endfunction

  // well-formed level word; with_tag puts the cascade tag in byte 0
  function automatic item_t level_word(input logic nc, input logic with_tag,
                                       input logic [7:0] sak);
    item_t w;
    w.new_card = nc;
    w.atqa     = 16'($urandom_range(0, 65535));
    for (int i = 0; i < 4; i++) w.frame[i] = 8'($urandom_range(0, 255));
    if (with_tag) begin
      w.frame[0] = CASCADE_TAG;
    end else if (w.frame[0] == CASCADE_TAG) begin
      w.frame[0] = 8'h08;
    end
    w.sak      = sak;
    w.anticoll = XR_OK;
    w.sel      = XR_OK;
    return sealed(w);
  endfunction

  function automatic logic [7:0] closing_sak();
    logic [7:0] s;
    case ($urandom_range(0, 8))
      0: s = SAK_MINI;
      1: s = SAK_CLASSIC1K;
      2: s = SAK_CLASSIC4K;
      3: s = SAK_ULTRALIGHT;
      4: s = SAK_PLUS_A;
      5: s = SAK_PLUS_B;
      6: s = SAK_ISO14443_4;
      7: s = SAK_ISO18092;
      default: s = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 3) == 0) s = s | 8'h80;
    return s & ~SAK_MORE;
  endfunction

  function automatic logic [7:0] cascading_sak();
    if ($urandom_range(0, 1) == 0) return SAK_INCOMPLETE;
    return 8'($urandom_range(0, 255)) | SAK_MORE;
  endfunction

  task automatic load_directed_cards();
    item_t w;
    w = level_word(1'b1, 1'b0, SAK_CLASSIC1K);
    w.frame = {4{8'hFF}};
    w.atqa  = 16'hFFFF;
    level_words.push_back(sealed(w));
    w = level_word(1'b0, 1'b0, SAK_ULTRALIGHT);
    w.frame = '0;
    w.atqa  = 16'h0000;
    level_words.push_back(sealed(w));
    // double and triple size
    level_words.push_back(level_word(1'b1, 1'b1, SAK_INCOMPLETE));
    level_words.push_back(level_word(1'b0, 1'b0, 8'hA0));
    level_words.push_back(level_word(1'b1, 1'b1, 8'hFF));
    level_words.push_back(level_word(1'b0, 1'b1, SAK_MORE));
    level_words.push_back(level_word(1'b0, 1'b0, SAK_ISO18092));
    // SAK asks for more levels, no cascade tag
    level_words.push_back(level_word(1'b1, 1'b0, SAK_INCOMPLETE));
    // tag alone cascades at level one; tag kept as UID byte at level two
    level_words.push_back(level_word(1'b1, 1'b1, SAK_CLASSIC4K));
    level_words.push_back(level_word(1'b0, 1'b1, SAK_MINI));
    // more bit without tag at level two, more bit at level three
    level_words.push_back(level_word(1'b1, 1'b1, SAK_MORE));
    level_words.push_back(level_word(1'b0, 1'b0, 8'h2C));
    level_words.push_back(level_word(1'b1, 1'b1, SAK_MORE));
    level_words.push_back(level_word(1'b0, 1'b1, SAK_MORE));
    level_words.push_back(level_word(1'b0, 1'b0, 8'h84));
    // exchange failures and their priority
    w = level_word(1'b1, 1'b0, SAK_CLASSIC1K);
    w.anticoll = XR_TIMEOUT;
    level_words.push_back(w);
    w.anticoll = XR_RF;
    level_words.push_back(w);
    w.anticoll = XR_OTHER;
    w.bcc      = w.bcc ^ 8'h01;
    level_words.push_back(w);
    w = level_word(1'b1, 1'b0, SAK_CLASSIC1K);
    w.bcc = w.bcc ^ 8'h80;
    w.sel = XR_RF;
    level_words.push_back(w);
    w = level_word(1'b1, 1'b0, SAK_CLASSIC1K);
    w.sel = XR_TIMEOUT;
    level_words.push_back(w);
    w.sel = XR_RF;
    level_words.push_back(w);
    w.sel = XR_OTHER;
    level_words.push_back(w);
    // new card abandons a cascade in progress
    level_words.push_back(level_word(1'b1, 1'b1, SAK_MORE));
    level_words.push_back(level_word(1'b1, 1'b0, SAK_PLUS_B));
    // failure at level two keeps the partial UID
    level_words.push_back(level_word(1'b1, 1'b1, SAK_MORE));
    w = level_word(1'b0, 1'b0, SAK_ULTRALIGHT);
    w.anticoll = XR_RF;
    level_words.push_back(w);
    level_words.push_back(level_word(1'b0, 1'b0, 8'h03));
  endtask

  task automatic load_random_cards();
    item_t w;
    int    depth;
    int    fault;
    int    target;
    logic  closing;
    target = level_words.size() + RANDOM_WORDS;
    while (level_words.size() < target) begin
      if ($urandom_range(0, 99) < 8) begin
        w.new_card = 1'($urandom_range(0, 1));
        w.atqa     = 16'($urandom_range(0, 65535));
        for (int i = 0; i < 4; i++) w.frame[i] = 8'($urandom_range(0, 255));
        w.bcc      = 8'($urandom_range(0, 255));
        w.sak      = 8'($urandom_range(0, 255));
        w.anticoll = xfer_result_t'($urandom_range(0, 3));
        w.sel      = xfer_result_t'($urandom_range(0, 3));
        level_words.push_back(w);
      end else begin
        depth = $urandom_range(1, 3);
        for (int lv = 1; lv <= depth; lv++) begin
          closing = (lv == depth);
          w = level_word(lv == 1 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0),
                         !closing, closing ? closing_sak() : cascading_sak());
          fault = $urandom_range(0, 99);
          if (fault < 4) begin
            w.anticoll = xfer_result_t'($urandom_range(1, 3));
          end else if (fault < 8) begin
            w.bcc = w.bcc ^ 8'($urandom_range(1, 255));
          end else if (fault < 12) begin
            w.sel = xfer_result_t'($urandom_range(1, 3));
          end else if (fault < 15) begin
            if (closing) begin
              w.sak = w.sak | SAK_MORE;
            end else begin
              w.frame[0] = w.frame[0] ^ 8'($urandom_range(1, 255));
              w = sealed(w);
            end
          end
          level_words.push_back(w);
          if (fault < 15 && $urandom_range(0, 1) == 0) break;
        end
      end
    end
  endtask

  task automatic drive_word(input item_t w);
    in_valid             <= 1'b1;
    new_card             <= w.new_card;
    answer_to_request_lo <= w.atqa[7:0];
    answer_to_request_hi <= w.atqa[15:8];
    frame_byte_0         <= w.frame[0];
    frame_byte_1         <= w.frame[1];
    frame_byte_2         <= w.frame[2];
    frame_byte_3         <= w.frame[3];
    check_byte           <= w.bcc;
    select_answer        <= w.sak;
    anticoll_result      <= w.anticoll;
    select_result        <= w.sel;
    do @(posedge clk); while (!in_ready);
    uid_track.take_level_word(w);
  endtask

  // result side: random stall pattern, changed when its window runs out
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.status     = status_t'(status);
      seen.next_level = next_level;
      seen.size       = uid_length;
      seen.uid        = {uid_high_bytes, uid_low_bytes};
      seen.sak        = final_select_answer;
      seen.atqa       = answer_to_request;
      seen.kind       = kind_t'(card_kind);
      uid_track.check_card_result(seen);
    end
    if (rx_window == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_window = $urandom_range(16, 96);
    end else begin
      rx_window--;
    end
    rx_toggle = ~rx_toggle;
    case (rx_mode)
      RX_FREE:      out_ready <= 1'b1;
      RX_ALTERNATE: out_ready <= rx_toggle;
      RX_COIN:      out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    int burst_left;
    load_directed_cards();
    load_random_cards();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 24);
    foreach (level_words[k]) begin
      drive_word(level_words[k]);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
    end
    in_valid <= 1'b0;
    while (uid_track.expected_cards.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (uid_track.failures == 0 && uid_track.expected_cards.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
